### sv/debounced_button_blink_speed_core_macros.svh
// assertion macros for the debounced button / blink speed core
// expects clk and rst_n in the scope of each use; no other dependencies
`ifndef DEBOUNCED_BUTTON_BLINK_SPEED_CORE_MACROS_SVH
`define DEBOUNCED_BUTTON_BLINK_SPEED_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DBBS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbbs assertion failed");
// next-cycle implication
`define DBBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbbs assertion failed");
`else
`define DBBS_ASSERT_IMPL(lbl, ante, cons)
`define DBBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/dbbs_pkg.sv
// shared types and constants for the debounced button / blink speed core
// no dependencies
package dbbs_pkg;

    localparam int unsigned PATTERN_LENGTH = 8;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_IDX_W      = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD     = 2'd2;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE_WINDOW = 16'd50;
    localparam logic [CFG_W-1:0] RST_FAST_PERIOD     = 16'd100;
    localparam logic [CFG_W-1:0] RST_SLOW_PERIOD     = 16'd200;

    typedef enum logic {
        CMD_TICK       = 1'b0,
        CMD_PIN_CHANGE = 1'b1
    } dbbs_cmd_t;

    typedef enum logic [1:0] {
        PH_WAIT_PRESS   = 2'd0,
        PH_DEB_PRESS    = 2'd1,
        PH_WAIT_RELEASE = 2'd2,
        PH_DEB_RELEASE  = 2'd3
    } dbbs_phase_t;

    typedef struct packed {
        logic cmd;
        logic pin_level;
    } dbbs_in_t;

    typedef struct packed {
        logic [2:0] led_position;
        logic       led_advanced;
        logic       fast_mode;
        logic [1:0] button_phase;
    } dbbs_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_window;
        logic [CFG_W-1:0] fast_period;
        logic [CFG_W-1:0] slow_period;
    } dbbs_cfg_t;

    typedef struct packed {
        logic        speed_fast;
        dbbs_phase_t phase;
    } dbbs_btn_t;

    typedef struct packed {
        logic [2:0] index;
        logic       stepped;
    } dbbs_led_t;

endpackage

### sv/dbbs_cfg.sv
// configuration registers: debounce window and the two blink periods
// depends on dbbs_pkg
module dbbs_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dbbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbbs_pkg::CFG_W-1:0]          cfg_data,
    output dbbs_pkg::dbbs_cfg_t                 cfg
);

    dbbs_pkg::dbbs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_window <= dbbs_pkg::RST_DEBOUNCE_WINDOW;
            cfg_reg.fast_period     <= dbbs_pkg::RST_FAST_PERIOD;
            cfg_reg.slow_period     <= dbbs_pkg::RST_SLOW_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dbbs_pkg::REG_DEBOUNCE_WINDOW: cfg_reg.debounce_window <= cfg_data;
                dbbs_pkg::REG_FAST_PERIOD:     cfg_reg.fast_period     <= cfg_data;
                dbbs_pkg::REG_SLOW_PERIOD:     cfg_reg.slow_period     <= cfg_data;
                default:                       ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/dbbs_debounce.sv
// millisecond counter, debounce stamp, press/release machine and speed flag
// depends on dbbs_pkg
module dbbs_debounce (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  dbbs_pkg::dbbs_in_t       item,
    input  logic [dbbs_pkg::CFG_W-1:0] window,
    output dbbs_pkg::dbbs_btn_t      btn_cur,
    output dbbs_pkg::dbbs_btn_t      btn_next
);

    logic [31:0]           ms_reg;
    logic [31:0]           ms_next;
    logic [31:0]           stamp_reg;
    logic [31:0]           stamp_next;
    dbbs_pkg::dbbs_phase_t phase_reg;
    dbbs_pkg::dbbs_phase_t phase_next;
    logic                  speed_reg;
    logic                  speed_next;
    logic [31:0]           ms_plus;
    logic [31:0]           elapsed;
    logic                  win_done;
    logic                  is_tick;
    logic                  stamp_load;
    logic                  speed_toggle;

    assign is_tick  = (item.cmd == dbbs_pkg::CMD_TICK);
    assign ms_plus  = ms_reg + 32'd1;
    // wraps modulo 2^32, so a counter rollover is harmless
    assign elapsed  = ms_plus - stamp_reg;
    assign win_done = (elapsed >= {16'd0, window});

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            case (phase_reg)
                dbbs_pkg::PH_WAIT_PRESS:
                begin
                    if (!is_tick)
                        phase_next = dbbs_pkg::PH_DEB_PRESS;
                end
                dbbs_pkg::PH_DEB_PRESS:
                begin
                    if (is_tick && win_done)
                        phase_next = item.pin_level ? dbbs_pkg::PH_WAIT_PRESS
                                                    : dbbs_pkg::PH_WAIT_RELEASE;
                end
                dbbs_pkg::PH_WAIT_RELEASE:
                begin
                    if (!is_tick)
                        phase_next = dbbs_pkg::PH_DEB_RELEASE;
                end
                dbbs_pkg::PH_DEB_RELEASE:
                begin
                    if (is_tick && win_done)
                        phase_next = item.pin_level ? dbbs_pkg::PH_WAIT_PRESS
                                                    : dbbs_pkg::PH_WAIT_RELEASE;
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // machine outputs
    always_comb
    begin
        stamp_load   = 1'b0;
        speed_toggle = 1'b0;
        if (fire && !is_tick)
        begin
            case (phase_reg)
                dbbs_pkg::PH_WAIT_PRESS:   stamp_load = 1'b1;
                dbbs_pkg::PH_WAIT_RELEASE:
                begin
                    stamp_load   = 1'b1;
                    speed_toggle = 1'b1;
                end
                default:
                begin
                    stamp_load   = 1'b0;
                    speed_toggle = 1'b0;
                end
            endcase
        end
    end

    assign ms_next    = (fire && is_tick) ? ms_plus : ms_reg;
    assign stamp_next = stamp_load ? ms_reg : stamp_reg;
    assign speed_next = speed_reg ^ speed_toggle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg    <= '0;
            stamp_reg <= '0;
            phase_reg <= dbbs_pkg::PH_WAIT_PRESS;
            speed_reg <= 1'b0;
        end
        else
        begin
            ms_reg    <= ms_next;
            stamp_reg <= stamp_next;
            phase_reg <= phase_next;
            speed_reg <= speed_next;
        end
    end

    assign btn_cur.speed_fast  = speed_reg;
    assign btn_cur.phase       = phase_reg;
    assign btn_next.speed_fast = speed_next;
    assign btn_next.phase      = phase_next;

endmodule

### sv/dbbs_blink.sv
// blink accumulator and led pattern index
// depends on dbbs_pkg
module dbbs_blink (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  dbbs_pkg::dbbs_in_t         item,
    input  logic                       speed_fast,
    input  dbbs_pkg::dbbs_cfg_t        cfg,
    output dbbs_pkg::dbbs_led_t        led_next
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [2:0]  index_reg;
    logic [2:0]  index_next;
    logic [15:0] period;
    logic [15:0] count_plus;
    logic [3:0]  index_plus;
    logic        step;

    assign period     = speed_fast ? cfg.fast_period : cfg.slow_period;
    assign count_plus = count_reg + 16'd1;
    assign index_plus = {1'b0, index_reg} + 4'd1;

    // a zero period, or accumulator wrap, steps at once
    assign step = fire && (item.cmd == dbbs_pkg::CMD_TICK)
                  && ((count_plus >= period) || (count_plus == 16'd0));

    always_comb
    begin
        count_next = count_reg;
        index_next = index_reg;
        if (fire && (item.cmd == dbbs_pkg::CMD_TICK))
        begin
            if (step)
            begin
                count_next = '0;
                if (32'(index_plus) >= dbbs_pkg::PATTERN_LENGTH)
                    index_next = '0;
                else
                    index_next = index_plus[2:0];
            end
            else
            begin
                count_next = count_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            index_reg <= index_next;
        end
    end

    assign led_next.index   = index_next;
    assign led_next.stepped = step;

endmodule

### sv/debounced_button_blink_speed_core.sv
// top level of the debounced button / blink speed core
// depends on dbbs_pkg, dbbs_cfg, dbbs_debounce, dbbs_blink and the macros header
//
//  channel   signals                          moves
//  in        in_valid / in_ready / in_data    one event (tick or pin change)
//  out       out_valid / out_ready / out_data one status result per event
//  cfg       cfg_we / cfg_index / cfg_data    register write, no wait
//
// one event per cycle sustained while the result side takes each result
// the rate is set by the state update, which commits as an event leaves the input register
// an input register feeds the update logic, a result register holds the answer
// a stalled result holds the input register, which then drops in_ready
// reset is asynchronous, active low, and restores the control and state registers to their defaults
`include "debounced_button_blink_speed_core_macros.svh"

module debounced_button_blink_speed_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  dbbs_pkg::dbbs_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output dbbs_pkg::dbbs_out_t              out_data,
    input  logic                             cfg_we,
    input  logic [dbbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbbs_pkg::CFG_W-1:0]       cfg_data
);

    // input register
    logic                s1_valid_reg;
    dbbs_pkg::dbbs_in_t  s1_item_reg;
    // result register
    logic                out_valid_reg;
    dbbs_pkg::dbbs_out_t out_data_reg;

    logic                out_free;
    logic                fire;
    logic                pin_fire;
    logic                toggle_fire;
    dbbs_pkg::dbbs_cfg_t cfg;
    dbbs_pkg::dbbs_btn_t btn_cur;
    dbbs_pkg::dbbs_btn_t btn_next;
    dbbs_pkg::dbbs_led_t led_next;

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;
    // the held event is processed and its state update committed
    assign fire     = s1_valid_reg && out_free;
    // take a new event when the input register is empty or draining
    assign in_ready = !s1_valid_reg || fire;

    // a pin change being processed, and one that toggles the speed
    assign pin_fire    = fire && (s1_item_reg.cmd == dbbs_pkg::CMD_PIN_CHANGE);
    assign toggle_fire = pin_fire && (btn_cur.phase == dbbs_pkg::PH_WAIT_RELEASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_data;
    end

    dbbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbbs_debounce u_debounce (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (s1_item_reg),
        .window   (cfg.debounce_window),
        .btn_cur  (btn_cur),
        .btn_next (btn_next)
    );

    // speed only changes on pin changes, so the current flag picks the tick period
    dbbs_blink u_blink (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (s1_item_reg),
        .speed_fast (btn_cur.speed_fast),
        .cfg        (cfg),
        .led_next   (led_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result reflects the state after the event
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg.led_position <= led_next.index;
            out_data_reg.led_advanced <= led_next.stepped;
            out_data_reg.fast_mode    <= btn_next.speed_fast;
            out_data_reg.button_phase <= btn_next.phase;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a processed event always leaves a result behind
    `DBBS_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)
    // a pin change never steps the led index
    `DBBS_ASSERT_NEXT(a_pin_no_step, pin_fire, !out_data.led_advanced)
    // an empty input register always takes a transfer
    `DBBS_ASSERT_IMPL(a_empty_ready, !s1_valid_reg, in_ready)
    // speed toggles only on a pin change while waiting for release
    `DBBS_ASSERT_NEXT(a_speed_hold, !toggle_fire, $stable(btn_cur.speed_fast))

endmodule

### test/debounced_button_blink_speed_core_test.sv
// self-checking bench for the debounced button / blink speed core
// depends on dbbs_pkg and debounced_button_blink_speed_core
// directed then random event streams, checked against a cycle-free model of the block
`timescale 1ns / 1ps

module debounced_button_blink_speed_core_test;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 8;        // wait after the result queues empty
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_EVENTS = 1100;
    localparam int PHASE_EVENTS  = 150;
    localparam int IDLE_PCT      = 20;
    localparam int CALM_PERIOD   = 4000;     // cycles from the start of one no-idle stretch to the next
    localparam int CALM_LENGTH   = 700;

    // index past the last register, writes there must be dropped
    localparam logic [dbbs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    dbbs_pkg::dbbs_in_t             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    dbbs_pkg::dbbs_out_t            out_data;
    logic                           cfg_we    = 1'b0;
    logic [dbbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dbbs_pkg::CFG_W-1:0]     cfg_data  = '0;

    // events waiting for the driver, status words waiting for the monitor
    dbbs_pkg::dbbs_in_t  pending_events_q[$];
    dbbs_pkg::dbbs_out_t expected_status_q[$];

    // shadow of the block's registers and state, reset values
    logic [dbbs_pkg::CFG_W-1:0] window_ms  = dbbs_pkg::RST_DEBOUNCE_WINDOW;
    logic [dbbs_pkg::CFG_W-1:0] fast_ms    = dbbs_pkg::RST_FAST_PERIOD;
    logic [dbbs_pkg::CFG_W-1:0] slow_ms    = dbbs_pkg::RST_SLOW_PERIOD;
    logic [31:0]                ms_count   = '0;
    logic [31:0]                deb_stamp  = '0;
    dbbs_pkg::dbbs_phase_t      btn_phase  = dbbs_pkg::PH_WAIT_PRESS;
    logic [15:0]                blink_acc  = '0;
    logic                       speed_fast = 1'b0;
    logic [2:0]                 led_idx    = '0;

    int  cycle_count   = 0;
    int  error_count   = 0;
    int  n_queued      = 0;
    int  n_ticks       = 0;
    int  n_pin_changes = 0;
    int  n_steps       = 0;
    int  n_toggles     = 0;
    int  n_writes      = 0;
    int  n_results     = 0;
    bit  in_fired      = 1'b0;
    logic calm;

    // recurring stretch where neither side idles
    assign calm = (cycle_count % CALM_PERIOD) < CALM_LENGTH;

    always #(CLK_HALF) clk = ~clk;

    debounced_button_blink_speed_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
    endtask

    // one event through the shadow state, returns the status word it should produce
    task automatic advance_button_state(input dbbs_pkg::dbbs_in_t ev,
                                        output dbbs_pkg::dbbs_out_t st);
        logic [15:0] period;
        logic [31:0] elapsed;
        logic [3:0]  nxt;
        logic        stepped;
        stepped = 1'b0;
        if (ev.cmd == dbbs_pkg::CMD_TICK)
        begin
            n_ticks++;
            period    = speed_fast ? fast_ms : slow_ms;
            ms_count  = ms_count + 32'd1;
            blink_acc = blink_acc + 16'd1;
            // a zero period or a period lowered under the count steps at once
            if (blink_acc >= period || blink_acc == 16'd0)
            begin
                nxt = {1'b0, led_idx} + 4'd1;
                if (nxt >= dbbs_pkg::PATTERN_LENGTH)
                    nxt = '0;
                led_idx   = nxt[2:0];
                blink_acc = '0;
                stepped   = 1'b1;
                n_steps++;
            end
            // debounce check runs on the counter after this tick, modulo 2^32
            elapsed = ms_count - deb_stamp;
            if (btn_phase == dbbs_pkg::PH_DEB_PRESS && elapsed >= window_ms)
                btn_phase = (ev.pin_level == 1'b0) ? dbbs_pkg::PH_WAIT_RELEASE
                                                   : dbbs_pkg::PH_WAIT_PRESS;
            else if (btn_phase == dbbs_pkg::PH_DEB_RELEASE && elapsed >= window_ms)
                btn_phase = (ev.pin_level == 1'b1) ? dbbs_pkg::PH_WAIT_PRESS
                                                   : dbbs_pkg::PH_WAIT_RELEASE;
        end
        else
        begin
            n_pin_changes++;
            // pin level plays no part here; debounce phases ignore the edge
            if (btn_phase == dbbs_pkg::PH_WAIT_PRESS)
            begin
                deb_stamp = ms_count;
                btn_phase = dbbs_pkg::PH_DEB_PRESS;
            end
            else if (btn_phase == dbbs_pkg::PH_WAIT_RELEASE)
            begin
                speed_fast = ~speed_fast;
                deb_stamp  = ms_count;
                btn_phase  = dbbs_pkg::PH_DEB_RELEASE;
                n_toggles++;
            end
        end
        st.led_position = led_idx;
        st.led_advanced = stepped;
        st.fast_mode    = speed_fast;
        st.button_phase = btn_phase;
    endtask

    task automatic queue_event(input dbbs_pkg::dbbs_cmd_t c, input logic pin);
        dbbs_pkg::dbbs_in_t ev;
        ev.cmd       = c;
        ev.pin_level = pin;
        pending_events_q.push_back(ev);
        n_queued++;
    endtask

    // register write takes effect at the rising edge, shadow follows there
    task automatic write_reg(input logic [dbbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbbs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            dbbs_pkg::REG_DEBOUNCE_WINDOW: window_ms = val;
            dbbs_pkg::REG_FAST_PERIOD:     fast_ms   = val;
            dbbs_pkg::REG_SLOW_PERIOD:     slow_ms   = val;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic set_config(input logic [dbbs_pkg::CFG_W-1:0] w,
                              input logic [dbbs_pkg::CFG_W-1:0] f,
                              input logic [dbbs_pkg::CFG_W-1:0] s, input bit poke_unused);
        write_reg(dbbs_pkg::REG_DEBOUNCE_WINDOW, w);
        write_reg(dbbs_pkg::REG_FAST_PERIOD, f);
        write_reg(dbbs_pkg::REG_SLOW_PERIOD, s);
        if (poke_unused)
            write_reg(REG_UNUSED, 16'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle once every queued event has a checked result
    task automatic wait_idle();
        while (pending_events_q.size() != 0 || in_valid || expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // press then release with bounce, pin held mostly steady across the window
    task automatic queue_button_cycle();
        int hold;
        repeat ($urandom_range(0, 3)) queue_event(dbbs_pkg::CMD_TICK, 1'($urandom_range(1)));
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'($urandom_range(1)));
        if ($urandom_range(3) == 0)
            queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'($urandom_range(1)));
        hold = (window_ms > 40) ? 40 : int'(window_ms);
        hold = hold + int'($urandom_range(0, 2));
        repeat (hold) queue_event(dbbs_pkg::CMD_TICK, ($urandom_range(4) == 0));
        repeat ($urandom_range(0, 4)) queue_event(dbbs_pkg::CMD_TICK, 1'b0);
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'($urandom_range(1)));
        if ($urandom_range(3) == 0)
            queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'($urandom_range(1)));
        hold = (window_ms > 40) ? 40 : int'(window_ms);
        hold = hold + int'($urandom_range(0, 2));
        repeat (hold) queue_event(dbbs_pkg::CMD_TICK, ($urandom_range(4) != 0));
    endtask

    function automatic logic [dbbs_pkg::CFG_W-1:0] pick_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 15));
        endcase
    endfunction

    // input driver: a new transfer is offered only after the last one went through
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            if (pending_events_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_events_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // monitor: checks result transfers, predicts on input transfers
    always @(posedge clk)
    begin : monitor
        dbbs_pkg::dbbs_out_t want_st;
        dbbs_pkg::dbbs_out_t next_st;
        in_fired = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_status_q.size() == 0)
                report_mismatch("result with nothing pending", int'(out_data), 0);
            else
            begin
                want_st = expected_status_q.pop_front();
                if (out_data.led_position !== want_st.led_position)
                    report_mismatch("led_position", int'(out_data.led_position),
                                    int'(want_st.led_position));
                if (out_data.led_advanced !== want_st.led_advanced)
                    report_mismatch("led_advanced", int'(out_data.led_advanced),
                                    int'(want_st.led_advanced));
                if (out_data.fast_mode !== want_st.fast_mode)
                    report_mismatch("fast_mode", int'(out_data.fast_mode),
                                    int'(want_st.fast_mode));
                if (out_data.button_phase !== want_st.button_phase)
                    report_mismatch("button_phase", int'(out_data.button_phase),
                                    int'(want_st.button_phase));
            end
        end
        if (in_fired)
        begin
            advance_button_state(in_data, next_st);
            expected_status_q.push_back(next_st);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_status_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_start;
        int random_start;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: start a press debounce under the 50 ms window
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b0);
        wait_idle();

        // zero window, zero fast period, slow period of one, dropped write to unused index
        set_config(16'd0, 16'd0, 16'd1, 1'b1);
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);          // bounce reverts to wait press
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b0);
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b1);    // ignored while debouncing
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);          // revert on released pin
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b1);
        queue_event(dbbs_pkg::CMD_TICK, 1'b0);          // confirm press
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b1);    // speed to fast
        queue_event(dbbs_pkg::CMD_TICK, 1'b0);          // release not confirmed
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b0);    // speed back to slow
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);          // release confirmed
        queue_event(dbbs_pkg::CMD_TICK, 1'b0);          // index runs through 7 and wraps
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);
        queue_event(dbbs_pkg::CMD_TICK, 1'b0);
        wait_idle();

        // largest window and periods: nothing confirms, nothing steps
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b1);
        repeat (3) queue_event(dbbs_pkg::CMD_TICK, 1'b0);
        repeat (2) queue_event(dbbs_pkg::CMD_TICK, 1'b1);
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b0);
        wait_idle();

        // slow period lowered under the accumulator, window of one
        set_config(16'd1, 16'hFFFF, 16'd2, 1'b0);
        queue_event(dbbs_pkg::CMD_TICK, 1'b0);
        queue_event(dbbs_pkg::CMD_PIN_CHANGE, 1'b0);
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);
        queue_event(dbbs_pkg::CMD_TICK, 1'b1);
        wait_idle();

        // random phases: mostly full press/release cycles, some raw noise
        random_start = n_queued;
        while (n_queued - random_start < RANDOM_EVENTS)
        begin
            set_config(($urandom_range(3) == 0) ? 16'($urandom_range(0, 2))
                                                : 16'($urandom_range(3, 30)),
                       pick_period(), pick_period(), ($urandom_range(3) == 0));
            phase_start = n_queued;
            while (n_queued - phase_start < PHASE_EVENTS
                   && n_queued - random_start < RANDOM_EVENTS)
            begin
                if ($urandom_range(99) < 80)
                    queue_button_cycle();
                else
                    repeat ($urandom_range(1, 6))
                        queue_event(dbbs_pkg::dbbs_cmd_t'($urandom_range(1)),
                                    1'($urandom_range(1)));
            end
            wait_idle();
        end

        $display("summary: %0d events (%0d ticks, %0d pin changes), %0d results checked",
                 n_queued, n_ticks, n_pin_changes, n_results);
        $display("summary: %0d led steps, %0d speed toggles, %0d register writes, %0d errors",
                 n_steps, n_toggles, n_writes, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
